@@ rtl/mbet_pkg.sv @@
// Shared types and constants for the Mandelbrot escape-time block.
package mbet_pkg;

    localparam int NUM_CELLS  = 4;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 8;

    localparam logic [2:0] REG_RE_START = 3'd0;
    localparam logic [2:0] REG_RE_STEP  = 3'd1;
    localparam logic [2:0] REG_IM_START = 3'd2;
    localparam logic [2:0] REG_IM_STEP  = 3'd3;
    localparam logic [2:0] REG_MAX_ITER = 3'd4;

    localparam logic [31:0] RST_RE_START = 32'hE000_0000;
    localparam logic [30:0] RST_RE_STEP  = 31'd1468006;
    localparam logic [31:0] RST_IM_START = 32'hE800_0000;
    localparam logic [30:0] RST_IM_STEP  = 31'd1677722;
    localparam logic [7:0]  RST_MAX_ITER = 8'd254;

    typedef struct packed {
        logic                  valid;
        logic                  done;
        logic [COUNT_BITS-1:0] count;
    } tok_t;

    typedef struct packed {
        logic [31:0]           re_start;
        logic [30:0]           re_step;
        logic [31:0]           im_start;
        logic [30:0]           im_step;
        logic [COUNT_BITS-1:0] max_iter;
    } cfg_t;

endpackage

@@ rtl/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time top level: point mapping, ring of iteration cells, result.
// Each accepted point circulates the ring, one iteration per cell (stages A and B), four
//   cells per lap, until it escapes or reaches max_iter; done then pulses.
// Throughput: one pixel at a time; busy is high from acceptance until the result cycle,
//   and a new request is taken in the cycle that done is high.
// The receiver cannot stall: done is high for exactly one cycle, and iter_count holds each result until the next.
// Reset (rst_n, async, active low) empties the ring and loads the default registers.
module mandelbrot_escape_time #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [COORD_BITS-1:0]           pixel_x,
    input  logic [COORD_BITS-1:0]           pixel_y,
    output logic                            done,
    output logic [mbet_pkg::COUNT_BITS-1:0] iter_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbet_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mbet_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mbet_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready
);

    localparam int W   = FRAC_BITS + 4;
    localparam int PRW = COORD_BITS + 31;
    localparam int CW  = (((PRW + 2) > W) ? (PRW + 2) : W) + 1;
    localparam int NC  = mbet_pkg::NUM_CELLS;

    localparam logic signed [CW-1:0] C_MAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = ~C_MAX;

    mbet_pkg::cfg_t cfg;

    mbet_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // point mapping
    logic [PRW-1:0]       re_prod, im_prod;
    logic signed [CW-1:0] re_sum, im_sum;
    logic [W-1:0]         c_re, c_im;

    always_comb
    begin
        re_prod = pixel_x * cfg.re_step;
        im_prod = pixel_y * cfg.im_step;
        re_sum  = CW'($signed(cfg.re_start)) + CW'(re_prod);
        im_sum  = CW'($signed(cfg.im_start)) + CW'(im_prod);
        if (re_sum > C_MAX)
            c_re = C_MAX[W-1:0];
        else if (re_sum < C_MIN)
            c_re = C_MIN[W-1:0];
        else
            c_re = re_sum[W-1:0];
        if (im_sum > C_MAX)
            c_im = C_MAX[W-1:0];
        else if (im_sum < C_MIN)
            c_im = C_MIN[W-1:0];
        else
            c_im = im_sum[W-1:0];
    end

    // ring of cells
    mbet_pkg::tok_t ring_tok [0:NC];
    logic [W-1:0]   ring_x   [0:NC];
    logic [W-1:0]   ring_y   [0:NC];
    logic [W-1:0]   ring_cre [0:NC];
    logic [W-1:0]   ring_cim [0:NC];

    mbet_pkg::tok_t head_tok;
    logic [W-1:0]   head_x, head_y, head_cre, head_cim;

    logic accept, emit;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [mbet_pkg::COUNT_BITS-1:0] iter_count_reg;

    assign accept = start & ~busy_reg;
    assign emit   = ring_tok[NC].valid & ring_tok[NC].done;

    always_comb
    begin
        if (accept)
        begin
            head_tok.valid = 1'b1;
            head_tok.done  = 1'b0;
            head_tok.count = '0;
            head_x   = '0;
            head_y   = '0;
            head_cre = c_re;
            head_cim = c_im;
        end
        else
        begin
            head_tok       = ring_tok[NC];
            head_tok.valid = ring_tok[NC].valid & ~ring_tok[NC].done;
            head_x   = ring_x[NC];
            head_y   = ring_y[NC];
            head_cre = ring_cre[NC];
            head_cim = ring_cim[NC];
        end
    end

    assign ring_tok[0] = head_tok;
    assign ring_x[0]   = head_x;
    assign ring_y[0]   = head_y;
    assign ring_cre[0] = head_cre;
    assign ring_cim[0] = head_cim;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        mbet_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .max_iter (cfg.max_iter),
            .tok_in   (ring_tok[i]),
            .x_in     (ring_x[i]),
            .y_in     (ring_y[i]),
            .cre_in   (ring_cre[i]),
            .cim_in   (ring_cim[i]),
            .tok_out  (ring_tok[i+1]),
            .x_out    (ring_x[i+1]),
            .y_out    (ring_y[i+1]),
            .cre_out  (ring_cre[i+1]),
            .cim_out  (ring_cim[i+1])
        );
    end

    // result and busy
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (emit)
            busy_next = 1'b0;
        done_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            iter_count_reg <= ring_tok[NC].count;
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign iter_count = iter_count_reg;

endmodule

@@ rtl/mbet_cfg.sv @@
// APB configuration registers for the Mandelbrot escape-time block.
module mbet_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbet_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mbet_pkg::DATA_BITS-1:0] pwdata,
    output logic [mbet_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output mbet_pkg::cfg_t                 cfg
);

    mbet_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.re_start <= mbet_pkg::RST_RE_START;
            cfg_reg.re_step  <= mbet_pkg::RST_RE_STEP;
            cfg_reg.im_start <= mbet_pkg::RST_IM_START;
            cfg_reg.im_step  <= mbet_pkg::RST_IM_STEP;
            cfg_reg.max_iter <= mbet_pkg::RST_MAX_ITER;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                mbet_pkg::REG_RE_START: cfg_reg.re_start <= pwdata;
                mbet_pkg::REG_RE_STEP:  cfg_reg.re_step  <= pwdata[30:0];
                mbet_pkg::REG_IM_START: cfg_reg.im_start <= pwdata;
                mbet_pkg::REG_IM_STEP:  cfg_reg.im_step  <= pwdata[30:0];
                mbet_pkg::REG_MAX_ITER: cfg_reg.max_iter <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            mbet_pkg::REG_RE_START: prdata = cfg_reg.re_start;
            mbet_pkg::REG_RE_STEP:  prdata = {1'b0, cfg_reg.re_step};
            mbet_pkg::REG_IM_START: prdata = cfg_reg.im_start;
            mbet_pkg::REG_IM_STEP:  prdata = {1'b0, cfg_reg.im_step};
            mbet_pkg::REG_MAX_ITER: prdata = {24'd0, cfg_reg.max_iter};
            default:                prdata = '0;
        endcase
    end

endmodule

@@ rtl/mbet_cell.sv @@
// One ring cell: a two-stage z = z^2 + c iteration with escape and limit test.
module mbet_cell #(
    parameter int FRAC_BITS = 28
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [mbet_pkg::COUNT_BITS-1:0] max_iter,
    input  mbet_pkg::tok_t                  tok_in,
    input  logic [FRAC_BITS+3:0]            x_in,
    input  logic [FRAC_BITS+3:0]            y_in,
    input  logic [FRAC_BITS+3:0]            cre_in,
    input  logic [FRAC_BITS+3:0]            cim_in,
    output mbet_pkg::tok_t                  tok_out,
    output logic [FRAC_BITS+3:0]            x_out,
    output logic [FRAC_BITS+3:0]            y_out,
    output logic [FRAC_BITS+3:0]            cre_out,
    output logic [FRAC_BITS+3:0]            cim_out
);

    localparam int W  = FRAC_BITS + 4;
    localparam int H  = W / 2;
    localparam int HI = W - H;
    localparam int PW = 2 * W + 2;

    localparam logic signed [PW-1:0] SAT_MAX   = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_MIN   = ~SAT_MAX;
    localparam logic signed [PW-1:0] ESC_LIMIT = PW'(4) << FRAC_BITS;

    function automatic logic [W-1:0] sat_comp(input logic signed [PW-1:0] v);
        if (v > SAT_MAX)
            return SAT_MAX[W-1:0];
        else if (v < SAT_MIN)
            return SAT_MIN[W-1:0];
        else
            return v[W-1:0];
    endfunction

    // stage A: partial products of 16-bit limbs
    logic signed [HI-1:0]   xh, yh;
    logic signed [H:0]      xl_s, yl_s;
    logic [H-1:0]           xl, yl;

    logic signed [2*HI-1:0] xx_hh_next, yy_hh_next, xy_hh_next;
    logic signed [W:0]      xx_hl_next, yy_hl_next, xy_hl_next, xy_lh_next;
    logic [2*H-1:0]         xx_ll_next, yy_ll_next, xy_ll_next;

    logic signed [2*HI-1:0] xx_hh_reg, yy_hh_reg, xy_hh_reg;
    logic signed [W:0]      xx_hl_reg, yy_hl_reg, xy_hl_reg, xy_lh_reg;
    logic [2*H-1:0]         xx_ll_reg, yy_ll_reg, xy_ll_reg;
    logic [W-1:0]           a_cre_reg, a_cim_reg;
    mbet_pkg::tok_t         a_tok_reg;

    always_comb
    begin
        xh   = $signed(x_in[W-1:H]);
        yh   = $signed(y_in[W-1:H]);
        xl   = x_in[H-1:0];
        yl   = y_in[H-1:0];
        xl_s = $signed({1'b0, xl});
        yl_s = $signed({1'b0, yl});
        xx_hh_next = xh * xh;
        yy_hh_next = yh * yh;
        xy_hh_next = xh * yh;
        xx_hl_next = xh * xl_s;
        yy_hl_next = yh * yl_s;
        xy_hl_next = xh * yl_s;
        xy_lh_next = yh * xl_s;
        xx_ll_next = xl * xl;
        yy_ll_next = yl * yl;
        xy_ll_next = xl * yl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_tok_reg <= '0;
        else
            a_tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        xx_hh_reg <= xx_hh_next;
        yy_hh_reg <= yy_hh_next;
        xy_hh_reg <= xy_hh_next;
        xx_hl_reg <= xx_hl_next;
        yy_hl_reg <= yy_hl_next;
        xy_hl_reg <= xy_hl_next;
        xy_lh_reg <= xy_lh_next;
        xx_ll_reg <= xx_ll_next;
        yy_ll_reg <= yy_ll_next;
        xy_ll_reg <= xy_ll_next;
        a_cre_reg <= cre_in;
        a_cim_reg <= cim_in;
    end

    // stage B: combine, scale, test, update
    logic signed [PW-1:0] p_xx, p_yy, p_xy;
    logic signed [PW-1:0] xx, yy, xy2, sq_sum, raw_x, raw_y;
    mbet_pkg::tok_t       b_tok_next, b_tok_reg;
    logic [W-1:0]         b_x_next, b_y_next;
    logic [W-1:0]         b_x_reg, b_y_reg, b_cre_reg, b_cim_reg;

    always_comb
    begin
        p_xx = (PW'(xx_hh_reg) <<< (2 * H)) + (PW'(xx_hl_reg) <<< (H + 1))
             + PW'(xx_ll_reg);
        p_yy = (PW'(yy_hh_reg) <<< (2 * H)) + (PW'(yy_hl_reg) <<< (H + 1))
             + PW'(yy_ll_reg);
        p_xy = (PW'(xy_hh_reg) <<< (2 * H)) + (PW'(xy_hl_reg) <<< H)
             + (PW'(xy_lh_reg) <<< H) + PW'(xy_ll_reg);
        xx     = p_xx >>> FRAC_BITS;
        yy     = p_yy >>> FRAC_BITS;
        xy2    = p_xy >>> (FRAC_BITS - 1);
        sq_sum = xx + yy;
        raw_x  = xx - yy + PW'($signed(a_cre_reg));
        raw_y  = xy2 + PW'($signed(a_cim_reg));
        b_x_next   = sat_comp(raw_x);
        b_y_next   = sat_comp(raw_y);
        b_tok_next = a_tok_reg;
        if (a_tok_reg.valid && !a_tok_reg.done)
        begin
            if (sq_sum >= ESC_LIMIT || a_tok_reg.count >= max_iter)
                b_tok_next.done = 1'b1;
            else
                b_tok_next.count = a_tok_reg.count + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_tok_reg <= '0;
        else
            b_tok_reg <= b_tok_next;
    end

    always_ff @(posedge clk)
    begin
        b_x_reg   <= b_x_next;
        b_y_reg   <= b_y_next;
        b_cre_reg <= a_cre_reg;
        b_cim_reg <= a_cim_reg;
    end

    assign tok_out = b_tok_reg;
    assign x_out   = b_x_reg;
    assign y_out   = b_y_reg;
    assign cre_out = b_cre_reg;
    assign cim_out = b_cim_reg;

endmodule

@@ rtl/mbet_checker.sv @@
// Port-level checks on request and result timing, bound to the top level.
module mbet_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not set after accepted request");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy high during result cycle");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

@@ dv/escape_count_checker.sv @@
// Checker for mandelbrot_escape_time: tracks the registers, predicts iter_count, compares.
module escape_count_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [11:0]                     pixel_x,
    input  logic [11:0]                     pixel_y,
    input  logic                            done,
    input  logic [mbet_pkg::COUNT_BITS-1:0] iter_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbet_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mbet_pkg::DATA_BITS-1:0]  pwdata,
    input  logic [mbet_pkg::DATA_BITS-1:0]  prdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              outstanding
);

    localparam int     FRAC   = 28;
    localparam longint Q_MAX  = 64'sd2147483647;
    localparam longint Q_MIN  = -Q_MAX - 1;
    localparam longint ESCAPE = 64'sd4 << FRAC;

    mbet_pkg::cfg_t                  cfg;
    logic [mbet_pkg::COUNT_BITS-1:0] expected_counts[$];
    logic [mbet_pkg::DATA_BITS-1:0]  reg_readback;
    logic                            reg_mapped;

    function automatic longint clamp_q4(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // z = z^2 + c from zero, floor-scaled products, saturating components
    function automatic logic [mbet_pkg::COUNT_BITS-1:0] escape_count(input logic [11:0] px,
                                                                     input logic [11:0] py);
        longint c_re;
        longint c_im;
        longint x;
        longint y;
        longint xx;
        longint yy;
        longint xy2;
        int     n;
        c_re = clamp_q4(longint'($signed(cfg.re_start))
                        + longint'(px) * longint'(cfg.re_step));
        c_im = clamp_q4(longint'($signed(cfg.im_start))
                        + longint'(py) * longint'(cfg.im_step));
        x = 0;
        y = 0;
        n = 0;
        while (n < int'(cfg.max_iter))
        begin
            xx = (x * x) >>> FRAC;
            yy = (y * y) >>> FRAC;
            if (xx + yy >= ESCAPE)
                break;
            xy2 = (x * y) >>> (FRAC - 1);
            x = clamp_q4(xx - yy + c_re);
            y = clamp_q4(xy2 + c_im);
            n++;
        end
        return mbet_pkg::COUNT_BITS'(n);
    endfunction

    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.re_start = mbet_pkg::RST_RE_START;
            cfg.re_step  = mbet_pkg::RST_RE_STEP;
            cfg.im_start = mbet_pkg::RST_IM_START;
            cfg.im_step  = mbet_pkg::RST_IM_STEP;
            cfg.max_iter = mbet_pkg::RST_MAX_ITER;
            expected_counts.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_counts.size() == 0)
                    log_mismatch($sformatf("iter_count %0d with no request pending", iter_count));
                else
                begin
                    if (iter_count !== expected_counts[0])
                        log_mismatch($sformatf("iter_count expected %0d, got %0d",
                                               expected_counts[0], iter_count));
                    void'(expected_counts.pop_front());
                end
            end
            if (start && !busy)
                expected_counts.push_back(escape_count(pixel_x, pixel_y));
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[4:2])
                        mbet_pkg::REG_RE_START: cfg.re_start = pwdata;
                        mbet_pkg::REG_RE_STEP:  cfg.re_step  = pwdata[30:0];
                        mbet_pkg::REG_IM_START: cfg.im_start = pwdata;
                        mbet_pkg::REG_IM_STEP:  cfg.im_step  = pwdata[30:0];
                        mbet_pkg::REG_MAX_ITER:
                            cfg.max_iter = pwdata[mbet_pkg::COUNT_BITS-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    reg_mapped = 1'b1;
                    case (paddr[4:2])
                        mbet_pkg::REG_RE_START: reg_readback = cfg.re_start;
                        mbet_pkg::REG_RE_STEP:  reg_readback = {1'b0, cfg.re_step};
                        mbet_pkg::REG_IM_START: reg_readback = cfg.im_start;
                        mbet_pkg::REG_IM_STEP:  reg_readback = {1'b0, cfg.im_step};
                        mbet_pkg::REG_MAX_ITER:
                            reg_readback = {{(mbet_pkg::DATA_BITS-mbet_pkg::COUNT_BITS){1'b0}},
                                            cfg.max_iter};
                        default:                reg_mapped = 1'b0;
                    endcase
                    if (reg_mapped && prdata !== reg_readback)
                        log_mismatch($sformatf("register %0d read expected %h, got %h",
                                               paddr[4:2], reg_readback, prdata));
                end
            end
        end
        outstanding = expected_counts.size();
    end

endmodule

@@ dv/testbench.sv @@
// Top of the mandelbrot_escape_time testbench: clock, reset, requests, register views, verdict.
module testbench;

    localparam logic [2:0] REG_UNMAPPED   = 3'd5;
    localparam int         PHASES         = 10;
    localparam int         RANDOM_ITEMS   = 1080;
    localparam int         CALM_TAIL      = 150;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SET_SPAN       = 805306368;  // 3.0 in Q4.28

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [11:0]                     pixel_x;
    logic [11:0]                     pixel_y;
    logic                            done;
    logic [mbet_pkg::COUNT_BITS-1:0] iter_count;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mbet_pkg::ADDR_BITS-1:0]  paddr;
    logic [mbet_pkg::DATA_BITS-1:0]  pwdata;
    logic [mbet_pkg::DATA_BITS-1:0]  prdata;
    logic                            pready;
    int                              fail_count;
    int                              outstanding;
    int                              quiet_cycles = 0;

    mandelbrot_escape_time dut (.*);

    escape_count_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("mandelbrot_escape_time regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
        @(negedge clk);
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic [2:0] idx, input logic wr,
                              input logic [mbet_pkg::DATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // program a full view of the plane, poke the unmapped slot, read every mapped register back
    task automatic load_view(input logic [31:0] rs, input logic [31:0] rstep,
                             input logic [31:0] is, input logic [31:0] istep,
                             input logic [31:0] limit);
        drain();
        apb_access(mbet_pkg::REG_RE_START, 1'b1, rs);
        apb_access(mbet_pkg::REG_RE_STEP, 1'b1, rstep);
        apb_access(mbet_pkg::REG_IM_START, 1'b1, is);
        apb_access(mbet_pkg::REG_IM_STEP, 1'b1, istep);
        apb_access(mbet_pkg::REG_MAX_ITER, 1'b1, limit);
        apb_access(REG_UNMAPPED, 1'b1, $urandom);
        for (int i = 0; i <= int'(mbet_pkg::REG_MAX_ITER); i++)
            apb_access(3'(i), 1'b0, '0);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] rs;
        logic [31:0] rstep;
        logic [31:0] is;
        logic [31:0] istep;
        logic [31:0] limit;
        logic [11:0] x;
        logic [11:0] y;
        int          sent;
        rst_n   = 1'b0;
        start   = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sent    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset view: corners, interior, the escape boundary at -2, bit patterns
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd100, 12'd240);
        send_pixel(12'd0, 12'd240);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);

        // zero limit
        load_view(32'hE000_0000, 32'd196608, 32'hE800_0000, 32'd196608, 32'h0000_FF00);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);

        // c saturates high and low, masked step bit, full limit
        load_view(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd255);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);

        load_view(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    rs    = $urandom;
                    rstep = $urandom;
                    is    = $urandom;
                    istep = $urandom;
                    limit = $urandom;
                end
                1:
                begin
                    rs    = 32'hE000_0000;
                    rstep = 32'd196608;
                    is    = 32'hE800_0000;
                    istep = 32'd196608;
                    limit = $urandom_range(1, 255);
                end
                default:
                begin
                    rs    = 32'hE000_0000 + $urandom_range(0, SET_SPAN);
                    is    = 32'hE800_0000 + $urandom_range(0, SET_SPAN);
                    rstep = $urandom_range(1, 1 << $urandom_range(4, 17));
                    istep = $urandom_range(1, 1 << $urandom_range(4, 17));
                    limit = ($urandom_range(0, 2) == 0) ? 32'd255 : $urandom_range(1, 96);
                end
            endcase
            load_view(rs, rstep, is, istep, limit);
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                sent++;
                if (sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 17));
                if ($urandom_range(0, 3) == 0)
                begin
                    x = 12'($urandom_range(0, 63));
                    y = 12'($urandom_range(0, 63));
                end
                else
                begin
                    x = 12'($urandom);
                    y = 12'($urandom);
                end
                send_pixel(x, y);
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("mandelbrot_escape_time regression: pass");
        else
            $display("mandelbrot_escape_time regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mbet_pkg.sv
rtl/mbet_cfg.sv
rtl/mbet_cell.sv
rtl/mandelbrot_escape_time.sv
rtl/mbet_checker.sv
dv/escape_count_checker.sv
dv/testbench.sv
